### src/clsu_pkg.sv
// ----------------------------------------------------------------------------
// clsu_pkg: shared definitions for the combined LCG shuffle generator
// Moduli, multipliers, table geometry, opcodes and the table port bundle.
// ----------------------------------------------------------------------------
package clsu_pkg;

   localparam int SAMPLE_W    = 31;
   localparam int TABLE_DEPTH = 32;
   localparam int WARM_EXTRA  = 8;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + WARM_EXTRA);

   localparam int MUL_W  = 16;
   localparam int PROD_W = SAMPLE_W + MUL_W;
   localparam int FOLD_W = 8;

   // m = 2^31 - fold, so 2^31 == fold (mod m)
   localparam logic [SAMPLE_W-1:0] MOD_ONE  = 31'd2147483563;
   localparam logic [MUL_W-1:0]    MUL_ONE  = 16'd40014;
   localparam logic [FOLD_W-1:0]   FOLD_ONE = 8'd85;
   localparam logic [SAMPLE_W-1:0] MOD_TWO  = 31'd2147483399;
   localparam logic [MUL_W-1:0]    MUL_TWO  = 16'd40692;
   localparam logic [FOLD_W-1:0]   FOLD_TWO = 8'd249;

   localparam int WRAP_SPAN = 2147483562;
   localparam int SLOT_DIV  = 1 + WRAP_SPAN / TABLE_DEPTH;

   localparam logic [SAMPLE_W-1:0] SECOND_SEED = 31'd123456789;

   localparam logic OP_DRAW   = 1'b0;
   localparam logic OP_RESEED = 1'b1;

   typedef enum logic {
      GEN_ONE = 1'b0,
      GEN_TWO = 1'b1
   } gen_sel_type;

   typedef struct packed {
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [SAMPLE_W-1:0] wr_data;
   } tbl_req_type;

   // table slot = value / SLOT_DIV, done as a row of constant compares
   function automatic logic [ADDR_W-1:0] slot_of(logic [SAMPLE_W-1:0] value);
      logic [ADDR_W-1:0] slot;
      slot = '0;
      for (int k = 1; k < TABLE_DEPTH; k++) begin
         if ({1'b0, value} >= 32'(k * SLOT_DIV)) begin
            slot = ADDR_W'(k);
         end
      end
      return slot;
   endfunction

endpackage

### src/combined_lcg_shuffle_uniform_rng.sv
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_uniform_rng: combined LCG with shuffle table
// Uniform integer generator, two congruential generators plus a shuffle.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_opcode, req_seed_value) is taken when req_valid is high
//   and req_stall is low. Opcode draw returns the next sample; opcode reseed
//   loads the seed (zero acts as one), warms up and fills the table, then
//   draws. Each request returns exactly one rsp_sample, handed over when
//   rsp_valid is high and rsp_stall is low; sample/2147483563 is the
//   uniform value.
//   Draw: the request passes the multiply, reduce and output steps before
//   its result is in the output register; no new request is taken until
//   the draw is done. Reseed adds a warm-up first: each warm-up step is one
//   pass through the modular multiply of the first generator.
//   The output register lets the next request be taken while a result
//   waits; a draw that finishes while the receiver stalls holds in its last
//   step until the output register frees up.
//   Reset sets the generators to 1 and 123456789, the last output to zero
//   and the table to all zeros; the block is ready the cycle after.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_uniform_rng (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [clsu_pkg::SAMPLE_W-1:0] req_seed_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [clsu_pkg::SAMPLE_W-1:0] rsp_sample
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_WARM_MUL = 6'b000010,
      S_WARM_RED = 6'b000100,
      S_DRAW_MUL = 6'b001000,
      S_DRAW_RED = 6'b010000,
      S_DRAW_OUT = 6'b100000
   } state_type;

   state_type                       state_ff, state_in;
   logic [clsu_pkg::SAMPLE_W-1:0]   gen1_ff, gen1_in;
   logic [clsu_pkg::SAMPLE_W-1:0]   gen2_ff, gen2_in;
   logic [clsu_pkg::SAMPLE_W-1:0]   last_ff, last_in;
   logic [clsu_pkg::ADDR_W-1:0]     slot_ff, slot_in;
   logic [clsu_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [clsu_pkg::SAMPLE_W-1:0]   rsp_sample_ff, rsp_sample_in;

   logic                            req_take;
   logic                            out_free;
   logic                            mul_load;
   logic [clsu_pkg::SAMPLE_W-1:0]   res1, res2;
   logic [clsu_pkg::SAMPLE_W-1:0]   tbl_rd_data;
   clsu_pkg::tbl_req_type           tbl_req;
   logic signed [clsu_pkg::SAMPLE_W+1:0] diff;
   logic [clsu_pkg::SAMPLE_W-1:0]   sample;

   clsu_modmul u_adv_one (
      .clock   (clock),
      .gen_sel (clsu_pkg::GEN_ONE),
      .load    (mul_load),
      .operand (gen1_ff),
      .result  (res1)
   );

   clsu_modmul u_adv_two (
      .clock   (clock),
      .gen_sel (clsu_pkg::GEN_TWO),
      .load    (mul_load),
      .operand (gen2_ff),
      .result  (res2)
   );

   clsu_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_data (tbl_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign mul_load  = (state_ff == S_WARM_MUL) || (state_ff == S_DRAW_MUL);

   // table value minus second generator, wrapped into 1..WRAP_SPAN
   always_comb begin
      diff = $signed({2'b00, tbl_rd_data}) - $signed({2'b00, gen2_ff});
      if (diff < 1) begin
         diff = diff + (clsu_pkg::SAMPLE_W+2)'(clsu_pkg::WRAP_SPAN);
      end
      sample = diff[clsu_pkg::SAMPLE_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      gen1_in       = gen1_ff;
      gen2_in       = gen2_ff;
      last_in       = last_ff;
      slot_in       = slot_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      tbl_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_opcode == clsu_pkg::OP_RESEED) begin
                  gen1_in  = (req_seed_value == '0) ? clsu_pkg::SAMPLE_W'(1)
                                                    : req_seed_value;
                  gen2_in  = gen1_in;
                  cnt_in   = clsu_pkg::CNT_W'(clsu_pkg::TABLE_DEPTH +
                                              clsu_pkg::WARM_EXTRA - 1);
                  state_in = S_WARM_MUL;
               end else begin
                  state_in = S_DRAW_MUL;
               end
            end
         end
         S_WARM_MUL: begin
            state_in = S_WARM_RED;
         end
         S_WARM_RED: begin
            gen1_in = res1;
            if (cnt_ff < clsu_pkg::CNT_W'(clsu_pkg::TABLE_DEPTH)) begin
               tbl_req.wr_en   = 1'b1;
               tbl_req.wr_addr = cnt_ff[clsu_pkg::ADDR_W-1:0];
               tbl_req.wr_data = res1;
            end
            if (cnt_ff == '0) begin
               last_in  = res1;
               state_in = S_DRAW_MUL;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = S_WARM_MUL;
            end
         end
         S_DRAW_MUL: begin
            slot_in         = clsu_pkg::slot_of(last_ff);
            tbl_req.rd_en   = 1'b1;
            tbl_req.rd_addr = slot_in;
            state_in        = S_DRAW_RED;
         end
         S_DRAW_RED: begin
            gen1_in  = res1;
            gen2_in  = res2;
            state_in = S_DRAW_OUT;
         end
         S_DRAW_OUT: begin
            if (out_free) begin
               tbl_req.wr_en   = 1'b1;
               tbl_req.wr_addr = slot_ff;
               tbl_req.wr_data = gen1_ff;
               last_in         = sample;
               rsp_valid_in    = 1'b1;
               rsp_sample_in   = sample;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gen1_ff      <= clsu_pkg::SAMPLE_W'(1);
         gen2_ff      <= clsu_pkg::SECOND_SEED;
         last_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen1_ff      <= gen1_in;
         gen2_ff      <= gen2_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

### src/clsu_modmul.sv
// ----------------------------------------------------------------------------
// clsu_modmul: constant modular multiply for one congruential generator
// Registered 31x16 product, then fold of the high part and one subtract.
// ----------------------------------------------------------------------------
module clsu_modmul (
   input  logic                          clock,
   input  clsu_pkg::gen_sel_type         gen_sel,
   input  logic                          load,
   input  logic [clsu_pkg::SAMPLE_W-1:0] operand,
   output logic [clsu_pkg::SAMPLE_W-1:0] result
);

   logic [clsu_pkg::PROD_W-1:0]          product_ff;
   logic [clsu_pkg::PROD_W-1:0]          product_in;
   logic [clsu_pkg::MUL_W-1:0]           mult;
   logic [clsu_pkg::FOLD_W-1:0]          fold;
   logic [clsu_pkg::SAMPLE_W-1:0]        modulus;
   logic [clsu_pkg::MUL_W-1:0]           hi;
   logic [clsu_pkg::SAMPLE_W-1:0]        lo;
   logic [clsu_pkg::MUL_W+clsu_pkg::FOLD_W-1:0] hi_fold;
   logic [clsu_pkg::SAMPLE_W:0]          sum;

   always_comb begin
      if (gen_sel == clsu_pkg::GEN_ONE) begin
         mult    = clsu_pkg::MUL_ONE;
         fold    = clsu_pkg::FOLD_ONE;
         modulus = clsu_pkg::MOD_ONE;
      end else begin
         mult    = clsu_pkg::MUL_TWO;
         fold    = clsu_pkg::FOLD_TWO;
         modulus = clsu_pkg::MOD_TWO;
      end
   end

   assign product_in = clsu_pkg::PROD_W'(operand) * clsu_pkg::PROD_W'(mult);

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

   // hi*2^31 + lo == hi*fold + lo (mod m); the sum stays below 2m
   always_comb begin
      hi      = product_ff[clsu_pkg::PROD_W-1:clsu_pkg::SAMPLE_W];
      lo      = product_ff[clsu_pkg::SAMPLE_W-1:0];
      hi_fold = (clsu_pkg::MUL_W+clsu_pkg::FOLD_W)'(hi) *
                (clsu_pkg::MUL_W+clsu_pkg::FOLD_W)'(fold);
      sum     = {1'b0, lo} + (clsu_pkg::SAMPLE_W+1)'(hi_fold);
      if (sum >= {1'b0, modulus}) begin
         result = clsu_pkg::SAMPLE_W'(sum - {1'b0, modulus});
      end else begin
         result = sum[clsu_pkg::SAMPLE_W-1:0];
      end
   end

endmodule

### src/clsu_table.sv
// ----------------------------------------------------------------------------
// clsu_table: shuffle table memory
// One write and one registered read per cycle; unwritten entries read zero.
// ----------------------------------------------------------------------------
module clsu_table (
   input  logic                          clock,
   input  logic                          reset,
   input  clsu_pkg::tbl_req_type         tbl_req,
   output logic [clsu_pkg::SAMPLE_W-1:0] rd_data
);

   logic [clsu_pkg::SAMPLE_W-1:0]    mem_ff [clsu_pkg::TABLE_DEPTH];
   logic [clsu_pkg::TABLE_DEPTH-1:0] valid_ff;
   logic [clsu_pkg::SAMPLE_W-1:0]    rd_data_ff;
   logic                             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem_ff[tbl_req.wr_addr] <= tbl_req.wr_data;
      end
      if (tbl_req.rd_en) begin
         rd_data_ff <= mem_ff[tbl_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (tbl_req.wr_en) begin
            valid_ff[tbl_req.wr_addr] <= 1'b1;
         end
         if (tbl_req.rd_en) begin
            rd_valid_ff <= valid_ff[tbl_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
